### hw/rtl/ptsb_pkg.sv
// Shared types, codes and constants for the planar tile sprite blitter.
package ptsb_pkg;

   // Default geometry of the target field and the tile set.
   localparam int DEF_FIELD_WIDTH  = 256;
   localparam int DEF_FIELD_HEIGHT = 128;
   localparam int DEF_TILE_COUNT   = 128;

   // Pattern store geometry.
   localparam int STORE_DEPTH = 2048;
   localparam int STORE_AW    = 11;
   localparam int TILE_SIDE   = 8;
   localparam int ROW_W       = 3;
   localparam int TILE_W      = 7;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Item opcodes.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_BLIT = 1'b1;

   // Register indexes on the CSR port.
   localparam logic [1:0] CSR_COLOR1 = 2'd0;
   localparam logic [1:0] CSR_COLOR2 = 2'd1;
   localparam logic [1:0] CSR_COLOR3 = 2'd2;

   // Palette reset values.
   localparam logic [7:0] RST_COLOR1 = 8'd18;
   localparam logic [7:0] RST_COLOR2 = 8'd33;
   localparam logic [7:0] RST_COLOR3 = 8'd51;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_BLIT,
      KIND_NOP
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROW,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      kind_type                    kind;
      logic [STORE_AW-1:0]         pattern_addr;
      logic [7:0]                  pattern_byte;
      logic [TILE_W-1:0]           tile;
      logic [8:0]                  dest_x;
      logic [8:0]                  dest_y;
   } item_type;

   typedef struct packed {
      logic [7:0] color1;
      logic [7:0] color2;
      logic [7:0] color3;
   } palette_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

### hw/rtl/ptsb_front.sv
// Front end: accepts request transfers, classifies them and feeds the queue.
module ptsb_front #(
   parameter int TILE_COUNT = ptsb_pkg::DEF_TILE_COUNT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_op,
   input  logic [10:0]                req_pattern_addr,
   input  logic [7:0]                 req_pattern_byte,
   input  logic [7:0]                 req_tile_index,
   input  logic [8:0]                 req_dest_x,
   input  logic [8:0]                 req_dest_y,
   input  ptsb_pkg::back_status_type  status,
   input  logic                       q_full,
   output logic                       q_push,
   output ptsb_pkg::item_type         q_item
);

   localparam logic [8:0] TILE_LIMIT = 9'(TILE_COUNT);

   logic                slot_valid_ff, slot_valid_in;
   ptsb_pkg::item_type  slot_ff, slot_in;
   logic                accept;

   assign q_push    = slot_valid_ff && !q_full;
   assign q_item    = slot_ff;
   assign req_stall = status.clearing || (slot_valid_ff && q_full);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      slot_in       = slot_ff;
      slot_valid_in = slot_valid_ff;
      if (q_push) begin
         slot_valid_in = 1'b0;
      end
      if (accept) begin
         slot_valid_in        = 1'b1;
         slot_in.pattern_addr = req_pattern_addr;
         slot_in.pattern_byte = req_pattern_byte;
         slot_in.tile         = req_tile_index[ptsb_pkg::TILE_W-1:0];
         slot_in.dest_x       = req_dest_x;
         slot_in.dest_y       = req_dest_y;
         if (req_op == ptsb_pkg::OP_LOAD) begin
            slot_in.kind = ptsb_pkg::KIND_LOAD;
         end else if ({1'b0, req_tile_index} < TILE_LIMIT) begin
            slot_in.kind = ptsb_pkg::KIND_BLIT;
         end else begin
            slot_in.kind = ptsb_pkg::KIND_NOP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
      slot_ff <= slot_in;
   end

endmodule

### hw/rtl/ptsb_queue.sv
// Short FIFO of classified items between front and back.
module ptsb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ptsb_pkg::item_type  push_item,
   output logic                full,
   input  logic                pop,
   output logic                valid,
   output ptsb_pkg::item_type  pop_item
);

   localparam int PW = (ptsb_pkg::QUEUE_DEPTH > 1) ? $clog2(ptsb_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(ptsb_pkg::QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(ptsb_pkg::QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(ptsb_pkg::QUEUE_DEPTH);

   ptsb_pkg::item_type  slots_ff [ptsb_pkg::QUEUE_DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign valid    = (count_ff != '0);
   assign pop_item = slots_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hw/rtl/ptsb_back.sv
// Back end: pattern store, clearing pass, tile scan and the response register.
module ptsb_back #(
   parameter int FIELD_WIDTH  = ptsb_pkg::DEF_FIELD_WIDTH,
   parameter int FIELD_HEIGHT = ptsb_pkg::DEF_FIELD_HEIGHT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  ptsb_pkg::item_type         q_item,
   output logic                       q_pop,
   input  ptsb_pkg::palette_type      palette,
   output ptsb_pkg::back_status_type  status,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [14:0]                rsp_pixel_addr,
   output logic [7:0]                 rsp_pixel_color,
   output logic                       rsp_last
);

   localparam int AW = ptsb_pkg::STORE_AW;
   localparam int RW = ptsb_pkg::ROW_W;
   localparam int TS = ptsb_pkg::TILE_SIDE;
   localparam logic [8:0]    FW9      = 9'(FIELD_WIDTH);
   localparam logic [8:0]    FH9      = 9'(FIELD_HEIGHT);
   localparam logic [AW-1:0] CLR_LAST = AW'(ptsb_pkg::STORE_DEPTH - 1);
   localparam logic [RW-1:0] ROW_LAST = RW'(TS - 1);

   // pattern store
   logic [7:0]       mem [ptsb_pkg::STORE_DEPTH];
   logic             mem_we, mem_re;
   logic [AW-1:0]    mem_wa;
   logic [7:0]       mem_wd;
   logic [7:0]       rd_lo_ff, rd_hi_ff;

   ptsb_pkg::state_type state_ff, state_in;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;
   logic [ptsb_pkg::TILE_W-1:0] tile_ff, tile_in;
   logic [8:0]       dx_ff, dx_in, dy_ff, dy_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [TS-1:0]    col_vis_ff, col_vis_in;
   logic [TS-1:0]    done_ff, done_in;
   logic [14:0]      row_base_ff, row_base_in;
   logic             hold_valid_ff, hold_valid_in;
   logic [14:0]      hold_addr_ff, hold_addr_in;
   logic [7:0]       hold_color_ff, hold_color_in;
   logic             rsp_valid_ff;
   logic [14:0]      rsp_addr_ff;
   logic [7:0]       rsp_color_ff;
   logic             rsp_last_ff;

   logic             out_load, out_last, out_free;
   logic [AW-1:0]    ra_lo, ra_hi;
   logic [9:0]       y_sum, x_sum;
   logic             row_vis;
   logic [16:0]      row_prod;
   logic [TS-1:0]    emit;
   logic             found;
   logic [RW-1:0]    sel_col;
   logic [7:0]       sel_color;
   logic [14:0]      sel_addr;
   logic [7:0]       x_low;

   function automatic logic [7:0] pal_color(input ptsb_pkg::palette_type p,
                                            input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd1:    c = p.color1;
         2'd2:    c = p.color2;
         2'd3:    c = p.color3;
         default: c = 8'd0;
      endcase
      return c;
   endfunction

   assign ra_lo = {tile_ff, 1'b0, row_ff};
   assign ra_hi = {tile_ff, 1'b1, row_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_lo_ff <= mem[ra_lo];
         rd_hi_ff <= mem[ra_hi];
      end
   end

   // row visibility and row base address
   assign y_sum    = {dy_ff[8], dy_ff} + {7'd0, row_ff};
   assign row_vis  = !y_sum[9] && (y_sum[8:0] < FH9);
   assign row_prod = y_sum[7:0] * FW9;

   // opaque, visible, not yet emitted pixels of the fetched row
   always_comb begin
      for (int c = 0; c < TS; c++) begin
         emit[c] = col_vis_ff[c] && !done_ff[c] &&
                   (pal_color(palette, {rd_hi_ff[TS-1-c], rd_lo_ff[TS-1-c]}) != 8'd0);
      end
      found   = 1'b0;
      sel_col = '0;
      for (int c = TS - 1; c >= 0; c--) begin
         if (emit[c]) begin
            found   = 1'b1;
            sel_col = RW'(c);
         end
      end
   end

   assign sel_color = pal_color(palette, {rd_hi_ff[ROW_LAST - sel_col],
                                          rd_lo_ff[ROW_LAST - sel_col]});
   assign x_low     = dx_ff[7:0] + {5'd0, sel_col};
   assign sel_addr  = row_base_ff + {7'd0, x_low};
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      tile_in       = tile_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      row_in        = row_ff;
      col_vis_in    = col_vis_ff;
      done_in       = done_ff;
      row_base_in   = row_base_ff;
      hold_valid_in = hold_valid_ff;
      hold_addr_in  = hold_addr_ff;
      hold_color_in = hold_color_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_wa        = clr_addr_ff;
      mem_wd        = 8'd0;
      out_load      = 1'b0;
      out_last      = 1'b0;
      x_sum         = '0;

      unique case (state_ff)
         ptsb_pkg::ST_CLEAR: begin
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == CLR_LAST) begin
               state_in = ptsb_pkg::ST_IDLE;
            end
         end
         ptsb_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_item.kind)
                  ptsb_pkg::KIND_LOAD: begin
                     mem_we = 1'b1;
                     mem_wa = q_item.pattern_addr;
                     mem_wd = q_item.pattern_byte;
                  end
                  ptsb_pkg::KIND_BLIT: begin
                     tile_in = q_item.tile;
                     dx_in   = q_item.dest_x;
                     dy_in   = q_item.dest_y;
                     row_in  = '0;
                     for (int c = 0; c < TS; c++) begin
                        x_sum         = {q_item.dest_x[8], q_item.dest_x} + 10'(c);
                        col_vis_in[c] = !x_sum[9] && (x_sum[8:0] < FW9);
                     end
                     state_in = ptsb_pkg::ST_ROW;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ptsb_pkg::ST_ROW: begin
            if (row_vis) begin
               mem_re      = 1'b1;
               row_base_in = row_prod[14:0];
               done_in     = '0;
               state_in    = ptsb_pkg::ST_SCAN;
            end else if (row_ff == ROW_LAST) begin
               state_in = ptsb_pkg::ST_FLUSH;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         ptsb_pkg::ST_SCAN: begin
            if (found) begin
               if (!hold_valid_ff || out_free) begin
                  out_load          = hold_valid_ff;
                  hold_valid_in     = 1'b1;
                  hold_addr_in      = sel_addr;
                  hold_color_in     = sel_color;
                  done_in[sel_col]  = 1'b1;
               end
            end else if (row_ff == ROW_LAST) begin
               state_in = ptsb_pkg::ST_FLUSH;
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = ptsb_pkg::ST_ROW;
            end
         end
         ptsb_pkg::ST_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = ptsb_pkg::ST_IDLE;
            end else if (out_free) begin
               out_load      = 1'b1;
               out_last      = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ptsb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptsb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ptsb_pkg::ST_CLEAR;
         clr_addr_ff   <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         hold_valid_ff <= hold_valid_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      tile_ff       <= tile_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      row_ff        <= row_in;
      col_vis_ff    <= col_vis_in;
      done_ff       <= done_in;
      row_base_ff   <= row_base_in;
      hold_addr_ff  <= hold_addr_in;
      hold_color_ff <= hold_color_in;
      if (out_load) begin
         rsp_addr_ff  <= hold_addr_ff;
         rsp_color_ff <= hold_color_ff;
         rsp_last_ff  <= out_last;
      end
   end

   assign status.clearing = (state_ff == ptsb_pkg::ST_CLEAR);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_addr  = rsp_addr_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

### hw/rtl/planar_tile_sprite_blitter.sv
// Top level of the planar 2bpp tile sprite blitter: CSRs, front, queue and back.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  req     | in  | req_valid/stall    | op, pattern_addr, pattern_byte, tile_index,
//          |     |                    | dest_x, dest_y
//  rsp     | out | rsp_valid/stall    | pixel_addr, pixel_color, last
//  csr     | in  | psel/penable/pready| paddr, pwrite, pwdata, prdata (3 palette regs)
//
// Steps: a load is written to the pattern store straight from idle; a blit starts from
// idle, then each tile row is skipped if off field, else fetched and scanned for its
// opaque visible pixels, and a flush step ends it. The pattern store port (one fetch
// per row) and the one-pixel-per-cycle scan, while rsp_stall is low, set the pace.
// Reset: synchronous; after reset a clearing pass zeroes the 2048-byte pattern store,
// during which req_stall stays high. CSR writes are taken throughout.
// Stalls: the queue lets the front keep taking transfers while the back is busy;
// a stalled response holds, and the back waits on it with one pixel held back to
// mark last.
module planar_tile_sprite_blitter #(
   parameter int FIELD_WIDTH  = ptsb_pkg::DEF_FIELD_WIDTH,
   parameter int FIELD_HEIGHT = ptsb_pkg::DEF_FIELD_HEIGHT,
   parameter int TILE_COUNT   = ptsb_pkg::DEF_TILE_COUNT
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [10:0]        req_pattern_addr,
   input  logic [7:0]         req_pattern_byte,
   input  logic [7:0]         req_tile_index,
   input  logic signed [8:0]  req_dest_x,
   input  logic signed [8:0]  req_dest_y,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [14:0]        rsp_pixel_addr,
   output logic [7:0]         rsp_pixel_color,
   output logic               rsp_last,
   // CSR port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   // palette registers
   logic [7:0]  color1_ff, color1_in;
   logic [7:0]  color2_ff, color2_in;
   logic [7:0]  color3_ff, color3_in;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   ptsb_pkg::palette_type      palette;
   ptsb_pkg::back_status_type  back_status;
   ptsb_pkg::item_type         front_item, queue_item;
   logic                       q_push, q_full, q_pop, q_valid;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      color1_in  = color1_ff;
      color2_in  = color2_ff;
      color3_in  = color3_ff;
      csr_prdata = '0;
      unique case (csr_idx)
         ptsb_pkg::CSR_COLOR1: begin
            csr_prdata = {24'd0, color1_ff};
            if (csr_wr) color1_in = csr_pwdata[7:0];
         end
         ptsb_pkg::CSR_COLOR2: begin
            csr_prdata = {24'd0, color2_ff};
            if (csr_wr) color2_in = csr_pwdata[7:0];
         end
         ptsb_pkg::CSR_COLOR3: begin
            csr_prdata = {24'd0, color3_ff};
            if (csr_wr) color3_in = csr_pwdata[7:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color1_ff <= ptsb_pkg::RST_COLOR1;
         color2_ff <= ptsb_pkg::RST_COLOR2;
         color3_ff <= ptsb_pkg::RST_COLOR3;
      end else begin
         color1_ff <= color1_in;
         color2_ff <= color2_in;
         color3_ff <= color3_in;
      end
   end

   assign palette.color1 = color1_ff;
   assign palette.color2 = color2_ff;
   assign palette.color3 = color3_ff;

   // accept and classify
   ptsb_front #(
      .TILE_COUNT (TILE_COUNT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_pattern_addr (req_pattern_addr),
      .req_pattern_byte (req_pattern_byte),
      .req_tile_index   (req_tile_index),
      .req_dest_x       (req_dest_x),
      .req_dest_y       (req_dest_y),
      .status           (back_status),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (front_item)
   );

   ptsb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (queue_item)
   );

   // store, scan and response
   ptsb_back #(
      .FIELD_WIDTH  (FIELD_WIDTH),
      .FIELD_HEIGHT (FIELD_HEIGHT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (queue_item),
      .q_pop           (q_pop),
      .palette         (palette),
      .status          (back_status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_addr  (rsp_pixel_addr),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last)
   );

   // no request transfer while the store is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> req_stall)
      else $error("request transfer during clearing pass");

   // the front never pushes into a full queue
   a_no_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("push into full queue");

   // the clearing pass starts right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> back_status.clearing && req_stall)
      else $error("clearing pass did not start after reset");

   // a response carries an opaque colour
   a_opaque_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |-> rsp_pixel_color != 8'd0)
      else $error("transparent pixel transferred");

endmodule

### test/tb.sv
// Self-checking testbench for the planar tile sprite blitter.
`timescale 1ns / 1ps

module tb;
   import ptsb_pkg::*;

   localparam int FIELD_W = DEF_FIELD_WIDTH;
   localparam int FIELD_H = DEF_FIELD_HEIGHT;
   localparam int TILES   = DEF_TILE_COUNT;

   // Settling time after the last expected write, for blits still queued with no output.
   localparam int SETTLE_CYCLES = 400;
   // Watchdog limit on the whole run, the clearing pass included.
   localparam int CYCLE_LIMIT   = 600000;
   localparam int LONG_HOLD     = 600;
   localparam int RAND_PHASES   = 4;
   localparam int PHASE_ITEMS   = 35;

   // Register index per pixel index 1..3.
   localparam logic [1:0] COLOR_REG [1:3] = '{CSR_COLOR1, CSR_COLOR2, CSR_COLOR3};

   // Fixed palette settings for the first random phases; the last one is random.
   localparam logic [7:0] PALETTE_SETS [3][3] = '{
      '{8'd255, 8'd255, 8'd255},
      '{8'd0,   8'd1,   8'd255},
      '{8'd1,   8'd0,   8'd0}
   };

   // Directed tile art: rows hit every 2-bit index, incl. the last store byte.
   localparam logic [7:0] TILE_ART [16] = '{
      8'hFF, 8'h00, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h81, 8'h7E,
      8'hFF, 8'hFF, 8'hCC, 8'h33, 8'h00, 8'hFF, 8'h18, 8'hE7
   };

   typedef struct {
      logic              op;
      logic [10:0]       paddr;
      logic [7:0]        pbyte;
      logic [7:0]        tile;
      logic signed [8:0] dx;
      logic signed [8:0] dy;
   } req_item_t;

   typedef struct {
      logic [14:0] addr;
      logic [7:0]  color;
      logic        last;
   } pixel_write_t;

   typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

   // Tracks the pattern store and palette, predicts pixel writes, checks them in order.
   class blit_scoreboard;
      logic [7:0]   pattern_mem [0:STORE_DEPTH-1];
      logic [7:0]   palette [1:3];
      pixel_write_t expected_writes [$];
      int           mismatches;
      int           writes_checked;
      int           blits_seen;
      int           loads_seen;

      function new();
         foreach (pattern_mem[i]) pattern_mem[i] = 8'h00;
         palette[1] = RST_COLOR1;
         palette[2] = RST_COLOR2;
         palette[3] = RST_COLOR3;
      endfunction

      task report(input string msg);
         $display("[%0t] MISMATCH: %s", $time, msg);
         mismatches++;
      endtask

      function void set_color(input int k, input logic [7:0] v);
         palette[k] = v;
      endfunction

      function int pending();
         return expected_writes.size();
      endfunction

      function void note_request(input req_item_t it);
         int           x;
         int           y;
         int           first;
         logic [10:0]  base;
         logic [7:0]   lo;
         logic [7:0]   hi;
         logic [1:0]   ix;
         pixel_write_t w;
         if (it.op == OP_LOAD) begin
            loads_seen++;
            pattern_mem[it.paddr] = it.pbyte;
            return;
         end
         blits_seen++;
         if (int'(it.tile) >= TILES) return;
         first = expected_writes.size();
         base  = 11'(int'(it.tile) * 16);
         for (int row = 0; row < TILE_SIDE; row++) begin
            y = int'(it.dy) + row;
            if (y < 0 || y >= FIELD_H) continue;
            lo = pattern_mem[11'(base + row)];
            hi = pattern_mem[11'(base + row + 8)];
            for (int col = 0; col < TILE_SIDE; col++) begin
               x = int'(it.dx) + col;
               if (x < 0 || x >= FIELD_W) continue;
               ix = {hi[7-col], lo[7-col]};
               if (ix == 2'd0) continue;
               if (palette[ix] == 8'h00) continue;
               w.addr  = 15'(y * FIELD_W + x);
               w.color = palette[ix];
               w.last  = 1'b0;
               expected_writes.push_back(w);
            end
         end
         // flag the final write of this blit
         if (expected_writes.size() > first) begin
            w = expected_writes.pop_back();
            w.last = 1'b1;
            expected_writes.push_back(w);
         end
      endfunction

      task check_write(input logic [14:0] addr, input logic [7:0] color, input logic last);
         pixel_write_t w;
         if (expected_writes.size() == 0) begin
            report($sformatf("unexpected write addr=%0d color=%0d last=%0b",
                             addr, color, last));
            return;
         end
         w = expected_writes.pop_front();
         if (addr !== w.addr)
            report($sformatf("write %0d: addr %0d, want %0d", writes_checked, addr, w.addr));
         if (color !== w.color)
            report($sformatf("write %0d: color %0d, want %0d", writes_checked, color, w.color));
         if (last !== w.last)
            report($sformatf("write %0d: last %0b, want %0b", writes_checked, last, w.last));
         writes_checked++;
      endtask
   endclass

   blit_scoreboard sb = new();

   // DUT signals; the ones the bench drives are known from time zero
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_op = OP_LOAD;
   logic [10:0]       req_pattern_addr = '0;
   logic [7:0]        req_pattern_byte = '0;
   logic [7:0]        req_tile_index = '0;
   logic signed [8:0] req_dest_x = '0;
   logic signed [8:0] req_dest_y = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [14:0]       rsp_pixel_addr;
   logic [7:0]        rsp_pixel_color;
   logic              rsp_last;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [3:0]        csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   int burst_left = 0;
   int long_hold_req = 0;
   int cycle_count = 0;
   int loaded_tiles [$];

   planar_tile_sprite_blitter #(
      .FIELD_WIDTH (FIELD_W),
      .FIELD_HEIGHT(FIELD_H),
      .TILE_COUNT  (TILES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_pattern_addr(req_pattern_addr),
      .req_pattern_byte(req_pattern_byte),
      .req_tile_index  (req_tile_index),
      .req_dest_x      (req_dest_x),
      .req_dest_y      (req_dest_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_addr  (rsp_pixel_addr),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Watchdog: a hung handshake or a missing write ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILED: results differ");
      $finish;
   end

   // Result monitor: every rsp transfer goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_write(rsp_pixel_addr, rsp_pixel_color, rsp_last);
   end

   // Receiver stall pattern; a long hold request is counted out here.
   initial begin
      rx_mode_e mode;
      int       mode_left;
      int       hold_left;
      int       tick;
      mode      = RX_FLOW;
      mode_left = 0;
      hold_left = 0;
      tick      = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req > 0) begin
            hold_left     = long_hold_req;
            long_hold_req = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_e'($urandom_range(0, 3));
               mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            tick++;
            case (mode)
               RX_FLOW:     rsp_stall <= 1'b0;
               RX_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
               RX_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= (tick % 3 == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- CSR access
   task automatic csr_write(input logic [3:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input logic [3:0] addr, output logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Read back one palette register against the scoreboard's copy.
   task automatic check_color_reg(input int k);
      logic [31:0] rd;
      csr_read({COLOR_REG[k], 2'b00}, rd);
      if (rd[7:0] !== sb.palette[k])
         sb.report($sformatf("palette reg %0d reads %0d, want %0d", k, rd[7:0], sb.palette[k]));
   endtask

   task automatic set_color(input int k, input logic [7:0] v);
      csr_write({COLOR_REG[k], 2'b00}, {24'h0, v});
      sb.set_color(k, v);
      check_color_reg(k);
   endtask

   // ---------------------------------------------------------------- request side
   function automatic req_item_t make_load(input logic [10:0] a, input logic [7:0] b);
      req_item_t it;
      it.op    = OP_LOAD;
      it.paddr = a;
      it.pbyte = b;
      // blit fields are don't-care on a load
      it.tile  = 8'($urandom());
      it.dx    = 9'($urandom());
      it.dy    = 9'($urandom());
      return it;
   endfunction

   function automatic req_item_t make_blit(input logic [7:0] t, input int x, input int y);
      req_item_t it;
      it.op    = OP_BLIT;
      it.paddr = 11'($urandom());
      it.pbyte = 8'($urandom());
      it.tile  = t;
      it.dx    = 9'(x);
      it.dy    = 9'(y);
      return it;
   endfunction

   // Sender pacing: bursts of random length with random gaps between them.
   task automatic pace_sender();
      burst_left--;
      if (burst_left <= 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 14)) @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end
   endtask

   // One req transfer: present at the falling edge, hold until taken.
   task automatic send_req(input req_item_t it);
      @(negedge clock);
      req_valid        <= 1'b1;
      req_op           <= it.op;
      req_pattern_addr <= it.paddr;
      req_pattern_byte <= it.pbyte;
      req_tile_index   <= it.tile;
      req_dest_x       <= it.dx;
      req_dest_y       <= it.dy;
      do @(posedge clock); while (req_stall);
      sb.note_request(it);
      pace_sender();
   endtask

   // Stop offering, let every expected write arrive, then let the back end go quiet.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_tile(input int t, input logic [7:0] art [16]);
      for (int b = 0; b < 16; b++)
         send_req(make_load(11'(t * 16 + b), art[b]));
   endtask

   // Random phase: a well-formed tile upload, then mostly blits of known tiles
   // near the field, with stray loads and wild blits mixed in.
   task automatic random_phase();
      logic [7:0] art [16];
      int         t;
      int         r;
      t = $urandom_range(0, TILES - 1);
      foreach (art[b]) art[b] = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom());
      load_tile(t, art);
      loaded_tiles.push_back(t);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         r = $urandom_range(0, 99);
         t = loaded_tiles[$urandom_range(0, loaded_tiles.size() - 1)];
         if (r < 65)
            send_req(make_blit(8'(t), $urandom_range(0, 267) - 12, $urandom_range(0, 147) - 12));
         else if (r < 80)
            send_req(make_load(11'($urandom()), 8'($urandom())));
         else if (r < 90)
            send_req(make_blit(8'($urandom()), int'($urandom()), int'($urandom())));
         else
            send_req(make_blit(8'(t), int'($urandom()), int'($urandom())));
      end
   endtask

   // ---------------------------------------------------------------- main sequence
   initial begin
      logic [7:0] v;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // palette must come up at its reset values
      for (int k = 1; k <= 3; k++) check_color_reg(k);

      // Directed: tile 127 covers the last store byte and every pixel index;
      // tile 0 gets one pixel at store address zero, tile 1 stays empty.
      load_tile(TILES - 1, TILE_ART);
      send_req(make_load(11'd0, 8'h80));
      loaded_tiles.push_back(TILES - 1);
      loaded_tiles.push_back(0);
      send_req(make_blit(8'(TILES - 1), 0, 0));
      send_req(make_blit(8'(TILES - 1), -7, -7));      // only the corner pixel lands
      send_req(make_blit(8'(TILES - 1), 248, 120));    // flush against bottom right
      send_req(make_blit(8'(TILES - 1), 252, 124));    // clipped right and bottom
      send_req(make_blit(8'(TILES - 1), 255, 127));
      send_req(make_blit(8'(TILES - 1), -256, -256));  // wholly off field
      send_req(make_blit(8'(TILES - 1), 255, 255));    // rows off field
      send_req(make_blit(8'd128, 0, 0));               // tile out of range
      send_req(make_blit(8'd255, 10, 10));
      send_req(make_blit(8'd0, 0, 0));                 // single write, carries last
      send_req(make_blit(8'd1, 20, 20));               // empty tile, no writes
      drain();

      for (int p = 0; p < RAND_PHASES; p++) begin
         for (int k = 1; k <= 3; k++) begin
            v = (p < 3) ? PALETTE_SETS[p][k-1] : 8'($urandom());
            set_color(k, v);
         end
         // back up the response side so the queue fills and req stalls
         if (p == 1) long_hold_req = LONG_HOLD;
         random_phase();
         drain();
      end

      $display("Covered %0d req transfers (%0d blits, %0d loads) across %0d palette settings.",
               sb.blits_seen + sb.loads_seen, sb.blits_seen, sb.loads_seen, RAND_PHASES + 1);
      $display("Checked %0d pixel writes in %0d cycles, %0d mismatches.",
               sb.writes_checked, cycle_count, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
